// File: rtl/core/keypad_alarm_code_controller_defines.svh
// Assertion macros for the checker file of this block.
`ifndef KEYPAD_ALARM_CODE_CONTROLLER_DEFINES_SVH
`define KEYPAD_ALARM_CODE_CONTROLLER_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define KACC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define KACC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/kacc_pkg.sv
package kacc_pkg;

  localparam int KACC_CODE_DIGITS = 4;

  localparam logic [7:0]  CODE_TIMEOUT_RESET = 8'd230;
  localparam logic [15:0] EXIT_DELAY_RESET   = 16'd1835;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_TIMEOUT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_DELAY   = 1'b1;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [3:0] KEY_A    = 4'd10;
  localparam logic [3:0] KEY_B    = 4'd11;
  localparam logic [3:0] KEY_C    = 4'd12;
  localparam logic [3:0] KEY_HASH = 4'd15;

  localparam logic [7:0] LEDS_DISARMED = 8'h02;
  localparam logic [7:0] LEDS_ARMED    = 8'h01;
  localparam logic [7:0] LEDS_ALARM    = 8'h03;
  localparam logic [7:0] LEDS_CHANGE   = 8'hFF;
  localparam logic [7:0] LEDS_OFF      = 8'h00;
  localparam logic [7:0] ZONE_A_LED    = 8'h80;
  localparam logic [7:0] ZONE_B_LED    = 8'h40;
  localparam logic [7:0] ZONE_C_LED    = 8'h20;

  typedef enum logic [2:0] {
    MODE_DISARMED  = 3'd0,
    MODE_ARMED     = 3'd1,
    MODE_TRIGGERED = 3'd2,
    MODE_CHANGE    = 3'd3,
    MODE_EXIT      = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PURPOSE_TOGGLE = 2'd0,
    PURPOSE_VERIFY = 2'd1,
    PURPOSE_ALARM  = 2'd2
  } purpose_t;

  typedef struct packed {
    logic [7:0] leds;
    mode_t      mode;
    logic       entry_active;
    logic       code_accepted;
  } result_t;

endpackage

// File: rtl/core/keypad_alarm_code_controller.sv
// Keypad code lock with a three-zone alarm.
// Input channel: in_valid/in_stall with req_type (0 key press, 1 timer tick)
// and key. A transaction takes place at a rising edge with in_valid high and
// in_stall low. Each input transaction produces exactly one output
// transaction on out_valid/out_stall carrying leds, mode, entry_active and
// code_accepted.
// The result is registered: it is loaded into the output register at the
// accepting edge unless that register holds an untaken result. One item is
// taken every cycle while in_stall is low; the whole state update is a
// single pass of logic between the input and the output register. When the
// receiver stalls, one more result is parked in a skid register, after which
// in_stall stays high until the receiver takes the output register's result.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
// edge they are presented: index 0 is the code timeout in ticks, index 1
// the exit delay in ticks.
// Synchronous reset returns to disarmed mode with code 0000, LEDs showing
// the disarmed pattern, no attempt running, timeout 230 and exit delay 1835.
module keypad_alarm_code_controller #(
  parameter int CODE_DIGITS = kacc_pkg::KACC_CODE_DIGITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kacc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kacc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [3:0]                       key,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       leds,
  output logic [2:0]                       mode,
  output logic                             entry_active,
  output logic                             code_accepted
);
  import kacc_pkg::*;

  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(CODE_DIGITS - 1);

  logic [7:0]       code_timeout;
  logic [15:0]      exit_delay;

  mode_t            sys_mode, sys_mode_next;
  logic [3:0]       code_store [CODE_DIGITS];
  logic [IDX_W-1:0] pos, pos_next;
  logic             failed, failed_next;
  logic             running, running_next;
  purpose_t         purpose, purpose_next;
  logic [15:0]      tick_count, tick_count_next;
  logic [7:0]       led_q, led_next;

  logic             code_we;
  logic             accept;
  logic             take;
  logic             accepted;
  logic             do_attempt;
  logic             zone_key;
  logic [7:0]       zone_led;
  logic [IDX_W-1:0] att_pos;
  logic             att_failed;
  logic [15:0]      tick_inc;
  result_t          res;
  result_t          skid;
  logic             skid_valid;

  assign accept = in_valid && !in_stall;
  assign take   = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_timeout <= CODE_TIMEOUT_RESET;
      exit_delay   <= EXIT_DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_TIMEOUT: code_timeout <= cfg_data[7:0];
        CFG_EXIT_DELAY:   exit_delay   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (key)
      KEY_A:   zone_led = ZONE_A_LED;
      KEY_B:   zone_led = ZONE_B_LED;
      KEY_C:   zone_led = ZONE_C_LED;
      default: zone_led = LEDS_OFF;
    endcase
    zone_key = (key == KEY_A) || (key == KEY_B) || (key == KEY_C);
  end

  assign att_pos    = running ? pos : '0;
  assign att_failed = running && failed;
  assign tick_inc   = tick_count + 16'd1;

  always_comb begin
    sys_mode_next   = sys_mode;
    pos_next        = pos;
    failed_next     = failed;
    running_next    = running;
    purpose_next    = purpose;
    tick_count_next = tick_count;
    led_next        = led_q;
    code_we         = 1'b0;
    accepted        = 1'b0;
    do_attempt      = 1'b0;

    if (accept) begin
      if (req_type == REQ_TICK) begin
        if (running) begin
          tick_count_next = tick_inc;
          if (tick_inc >= {8'd0, code_timeout}) begin
            pos_next        = '0;
            failed_next     = 1'b0;
            tick_count_next = '0;
            if (purpose != PURPOSE_ALARM) begin
              running_next = 1'b0;
            end
            if (purpose == PURPOSE_VERIFY) begin
              sys_mode_next = MODE_DISARMED;
              led_next      = LEDS_DISARMED;
            end
          end
        end else if (sys_mode == MODE_EXIT) begin
          tick_count_next = tick_inc;
          if (tick_inc >= exit_delay) begin
            sys_mode_next   = MODE_ARMED;
            led_next        = LEDS_ARMED;
            tick_count_next = '0;
          end
        end
      end else begin
        priority if (running) begin
          do_attempt = 1'b1;
        end else if (sys_mode == MODE_CHANGE) begin
          code_we  = 1'b1;
          led_next = led_q | {key, 4'b0000};
          if (pos == LAST_POS) begin
            pos_next      = '0;
            sys_mode_next = MODE_DISARMED;
            led_next      = LEDS_DISARMED;
          end else begin
            pos_next = pos + IDX_W'(1);
          end
        end else if (sys_mode == MODE_ARMED && zone_key) begin
          sys_mode_next   = MODE_TRIGGERED;
          led_next        = LEDS_ALARM | zone_led;
          running_next    = 1'b1;
          purpose_next    = PURPOSE_ALARM;
          pos_next        = '0;
          failed_next     = 1'b0;
          tick_count_next = '0;
        end else if (sys_mode == MODE_DISARMED && key == KEY_HASH) begin
          sys_mode_next   = MODE_CHANGE;
          led_next        = LEDS_OFF;
          running_next    = 1'b1;
          purpose_next    = PURPOSE_VERIFY;
          pos_next        = '0;
          failed_next     = 1'b0;
          tick_count_next = '0;
        end else if (sys_mode == MODE_ARMED || sys_mode == MODE_DISARMED) begin
          do_attempt = 1'b1;
        end else begin
        end
      end
    end

    if (do_attempt) begin
      running_next = 1'b1;
      pos_next     = att_pos;
      failed_next  = att_failed;
      if (!running) begin
        purpose_next    = PURPOSE_TOGGLE;
        tick_count_next = '0;
      end
      if (!att_failed) begin
        led_next = led_q | {key, 4'b0000};
        if (key == code_store[att_pos]) begin
          if (att_pos == LAST_POS) begin
            accepted = 1'b1;
          end else begin
            pos_next = att_pos + IDX_W'(1);
          end
        end else begin
          failed_next = 1'b1;
        end
      end
    end

    if (accepted) begin
      running_next    = 1'b0;
      pos_next        = '0;
      failed_next     = 1'b0;
      tick_count_next = '0;
      unique case (purpose_next)
        PURPOSE_VERIFY: begin
          sys_mode_next = MODE_CHANGE;
          led_next      = LEDS_CHANGE;
        end
        PURPOSE_ALARM: begin
          sys_mode_next = MODE_EXIT;
          led_next      = LEDS_OFF;
        end
        default: begin
          if (sys_mode == MODE_ARMED) begin
            sys_mode_next = MODE_DISARMED;
            led_next      = LEDS_DISARMED;
          end else begin
            sys_mode_next = MODE_ARMED;
            led_next      = LEDS_ARMED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_mode   <= MODE_DISARMED;
      pos        <= '0;
      failed     <= 1'b0;
      running    <= 1'b0;
      purpose    <= PURPOSE_TOGGLE;
      tick_count <= '0;
      led_q      <= LEDS_DISARMED;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        code_store[i] <= 4'd0;
      end
    end else begin
      sys_mode   <= sys_mode_next;
      pos        <= pos_next;
      failed     <= failed_next;
      running    <= running_next;
      purpose    <= purpose_next;
      tick_count <= tick_count_next;
      led_q      <= led_next;
      if (code_we) begin
        code_store[pos] <= key;
      end
    end
  end

  assign res.leds          = led_next;
  assign res.mode          = sys_mode_next;
  assign res.entry_active  = running_next;
  assign res.code_accepted = accepted;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        {leds, mode, entry_active, code_accepted} <= skid;
      end
    end else if (accept) begin
      if (out_valid && !take) begin
        skid <= res;
      end else begin
        {leds, mode, entry_active, code_accepted} <= res;
      end
    end
  end

endmodule

// File: rtl/core/kacc_checker.sv
`include "keypad_alarm_code_controller_defines.svh"

module kacc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic [kacc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [kacc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             req_type,
  input logic [3:0]                       key,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [7:0]                       leds,
  input logic [2:0]                       mode,
  input logic                             entry_active,
  input logic                             code_accepted
);
  import kacc_pkg::*;

  logic unused_inputs;
  assign unused_inputs = cfg_we ^ (^cfg_index) ^ (^cfg_data) ^ in_valid ^ in_stall ^
                         req_type ^ (^key);

  `KACC_ASSERT(a_out_held, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `KACC_ASSERT(a_accept_ends_entry, out_valid && code_accepted |-> !entry_active, "accepted code left an attempt running")
  `KACC_ASSERT(a_alarm_asks_code, out_valid && mode == MODE_TRIGGERED |-> entry_active, "triggered alarm without a code attempt")
  `KACC_ASSERT(a_change_shows_all, out_valid && code_accepted && mode == MODE_CHANGE |-> leds == LEDS_CHANGE, "change mode entered with wrong LEDs")

endmodule

bind keypad_alarm_code_controller kacc_checker u_kacc_checker (.*);
